FILE: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants
// Word layouts, fixed widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int MOM_W    = 24;   // momentum component width
  localparam int MAG_W    = 24;
  localparam int ANG_W    = 16;
  localparam int POL_W    = 15;
  localparam int EN_W     = 40;
  localparam int MASS_W   = 32;
  localparam int ACC_W    = 20;   // angle accumulator, 16 fraction bits
  localparam int PRESCALE = 28;
  localparam int EV_W     = 48;   // eV energy before saturation
  localparam int TAB_N    = 24;

  localparam logic [MASS_W-1:0] MASS_RESET = 32'd470054;
  localparam logic [EN_W-1:0]   ENERGY_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0]  MAG_MAX    = 24'hFF_FFFF;

  localparam logic signed [ACC_W-1:0] PI_16 = 20'sd205887;
  localparam logic signed [ANG_W-1:0] PI_13 = 16'sd25736;

  // round(atan(2^-i) * 2^16)
  localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_N] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
  };

  typedef struct packed {
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic signed [MOM_W-1:0] mom_z;
  } mts_in_t;

  typedef struct packed {
    logic [MAG_W-1:0]        magnitude;
    logic signed [ANG_W-1:0] azimuth;
    logic [POL_W-1:0]        polar_angle;
    logic [EN_W-1:0]         energy_au;
    logic [EN_W-1:0]         energy_ev;
  } mts_out_t;

endpackage

FILE: sv/mts_delay.sv
// ----------------------------------------------------------------------------
// mts_delay: staged delay line
// Carries side data alongside the compute stages; each tap loads with its stage.
// ----------------------------------------------------------------------------
module mts_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [N-1:0] load,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] tap [N];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      tap[0] <= din;
    end
    for (int i = 1; i < N; i++) begin
      if (load[i]) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign dout = tap[N-1];

endmodule

FILE: sv/mts_divider.sv
// ----------------------------------------------------------------------------
// mts_divider: pipelined restoring divider
// One quotient bit per stage, NW stages, floor(num / den).
// ----------------------------------------------------------------------------
module mts_divider #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] load,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem      [NW];
  logic [NW-1:0] nq       [NW];   // dividend bits shift out, quotient bits in
  logic [DW-1:0] rem_next [NW];
  logic [NW-1:0] nq_next  [NW];

  always_comb begin
    logic [DW-1:0] r_in;
    logic [NW-1:0] n_in;
    logic [DW:0]   t;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        r_in = '0;
        n_in = num;
      end else begin
        r_in = rem[k-1];
        n_in = nq[k-1];
      end
      t = {r_in, n_in[NW-1]};
      if (t >= {1'b0, den}) begin
        rem_next[k] = DW'(t - {1'b0, den});
        nq_next[k]  = {n_in[NW-2:0], 1'b1};
      end else begin
        rem_next[k] = t[DW-1:0];
        nq_next[k]  = {n_in[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      if (load[k]) begin
        rem[k] <= rem_next[k];
        nq[k]  <= nq_next[k];
      end
    end
  end

  assign quo = nq[NW-1];

endmodule

FILE: sv/mts_sqrt.sv
// ----------------------------------------------------------------------------
// mts_sqrt: pipelined integer square root
// Digit-by-digit method, one root bit per stage, floor(sqrt(num)).
// ----------------------------------------------------------------------------
module mts_sqrt #(
  parameter int NW = 16   // even
) (
  input  logic              clk,
  input  logic [NW/2-1:0]   load,
  input  logic [NW-1:0]     num,
  output logic [NW/2-1:0]   root_out
);

  localparam int RTW = NW / 2;
  localparam int RB  = RTW + 1;

  logic [NW-1:0]  nsh       [RTW];
  logic [RB-1:0]  rem       [RTW];
  logic [RTW-1:0] root      [RTW];
  logic [NW-1:0]  nsh_next  [RTW];
  logic [RB-1:0]  rem_next  [RTW];
  logic [RTW-1:0] root_next [RTW];

  always_comb begin
    logic [NW-1:0]  n_in;
    logic [RB-1:0]  r_in;
    logic [RTW-1:0] rt_in;
    logic [RB+1:0]  t;
    logic [RB+1:0]  trial;
    for (int k = 0; k < RTW; k++) begin
      if (k == 0) begin
        n_in  = num;
        r_in  = '0;
        rt_in = '0;
      end else begin
        n_in  = nsh[k-1];
        r_in  = rem[k-1];
        rt_in = root[k-1];
      end
      t     = {r_in, n_in[NW-1:NW-2]};
      trial = (RB+2)'({rt_in, 2'b01});
      nsh_next[k] = {n_in[NW-3:0], 2'b00};
      if (t >= trial) begin
        rem_next[k]  = RB'(t - trial);
        root_next[k] = {rt_in[RTW-2:0], 1'b1};
      end else begin
        rem_next[k]  = t[RB-1:0];
        root_next[k] = {rt_in[RTW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RTW; k++) begin
      if (load[k]) begin
        nsh[k]  <= nsh_next[k];
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
      end
    end
  end

  assign root_out = root[RTW-1];

endmodule

FILE: sv/mts_cordic.sv
// ----------------------------------------------------------------------------
// mts_cordic: pipelined vectoring CORDIC
// atan2(y, x) with 13 fraction bits: pre-rotation stage, STEPS iterations,
// round and clamp stage.
// ----------------------------------------------------------------------------
module mts_cordic #(
  parameter int IW    = 26,
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic [STEPS+1:0]              load,
  input  logic signed [IW-1:0]          x_in,
  input  logic signed [IW-1:0]          y_in,
  output logic signed [mts_pkg::ANG_W-1:0] angle
);

  import mts_pkg::*;

  localparam int W = IW + 30;

  logic signed [W-1:0]     x_r      [STEPS+1];
  logic signed [W-1:0]     y_r      [STEPS+1];
  logic signed [ACC_W-1:0] acc_r    [STEPS+1];
  logic                    zero_r   [STEPS+1];
  logic                    neg_r    [STEPS+1];
  logic signed [W-1:0]     x_next   [STEPS+1];
  logic signed [W-1:0]     y_next   [STEPS+1];
  logic signed [ACC_W-1:0] acc_next [STEPS+1];
  logic signed [ANG_W-1:0] angle_next;

  always_comb begin
    logic                 xneg;
    logic signed [IW-1:0] xa;
    logic signed [IW-1:0] ya;
    // pre-rotation: fold left half-plane by pi, then scale up
    xneg = x_in < 0;
    xa   = xneg ? -x_in : x_in;
    ya   = xneg ? -y_in : y_in;
    x_next[0] = W'(xa) <<< PRESCALE;
    y_next[0] = W'(ya) <<< PRESCALE;
    if (!xneg) begin
      acc_next[0] = '0;
    end else if (y_in >= 0) begin
      acc_next[0] = PI_16;
    end else begin
      acc_next[0] = -PI_16;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y_r[i] >= 0) begin
        x_next[i+1]   = x_r[i] + (y_r[i] >>> i);
        y_next[i+1]   = y_r[i] - (x_r[i] >>> i);
        acc_next[i+1] = acc_r[i] + ATAN_TAB[i];
      end else begin
        x_next[i+1]   = x_r[i] - (y_r[i] >>> i);
        y_next[i+1]   = y_r[i] + (x_r[i] >>> i);
        acc_next[i+1] = acc_r[i] - ATAN_TAB[i];
      end
    end
  end

  // round to 13 fraction bits, clamp to +/- pi; y == 0 gives an exact angle
  always_comb begin
    logic signed [ACC_W-1:0] res;
    res = (acc_r[STEPS] + ACC_W'(4)) >>> 3;
    if (zero_r[STEPS]) begin
      angle_next = neg_r[STEPS] ? PI_13 : '0;
    end else if (res > ACC_W'(PI_13)) begin
      angle_next = PI_13;
    end else if (res < -ACC_W'(PI_13)) begin
      angle_next = -PI_13;
    end else begin
      angle_next = res[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      x_r[0]    <= x_next[0];
      y_r[0]    <= y_next[0];
      acc_r[0]  <= acc_next[0];
      zero_r[0] <= y_in == 0;
      neg_r[0]  <= x_in < 0;
    end
    for (int i = 1; i <= STEPS; i++) begin
      if (load[i]) begin
        x_r[i]    <= x_next[i];
        y_r[i]    <= y_next[i];
        acc_r[i]  <= acc_next[i];
        zero_r[i] <= zero_r[i-1];
        neg_r[i]  <= neg_r[i-1];
      end
    end
    if (load[STEPS+1]) begin
      angle <= angle_next;
    end
  end

endmodule

FILE: sv/momentum_to_spherical_energy.sv
// ----------------------------------------------------------------------------
// momentum_to_spherical_energy: momentum vector to spherical coords and energy
// Magnitude, azimuth, polar angle and kinetic energy (au and eV) per vector.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | word
//  --------+----------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data      | mom_x, mom_y, mom_z
//  out     | out_valid, out_ready, out_data   | magnitude, azimuth, polar_angle,
//          |                                  | energy_au, energy_ev
//  cfg     | cfg_we, cfg_data                 | particle_mass
//
//  One word per cycle sustained while out_ready stays high. The pipeline
//  length is set by the energy path: input, squares and sums (3 stages), the
//  restoring divider by 2*mass (one quotient bit per stage over the 50-bit
//  sum of squares), five stages for the eV scaling, then the output register.
//  Reset clears all stage valid bits and loads particle_mass with 470054.
//  An occupied stage holds only while the next one holds; bubbles collapse,
//  so input is still taken while a finished word waits, if any stage is free.
//
module momentum_to_spherical_energy #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mts_pkg::mts_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mts_pkg::mts_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [mts_pkg::MASS_W-1:0] cfg_data
);

  import mts_pkg::*;

  localparam int MW   = MOM_W;
  localparam int CS   = CORDIC_STEPS;
  localparam int SW   = 2 * MW + 2;          // sum of squares
  localparam int SQ   = MW + 1;              // sqrt stages / root width
  localparam int QW   = SW;                  // divider stages
  localparam int QEW  = (QW > EN_W + 1) ? QW : EN_W + 1;
  localparam int IW   = MW + 2;              // CORDIC operand width
  localparam int C0   = 3 + SQ;              // CORDIC pre-rotation stage
  localparam int CEND = C0 + CS + 1;         // CORDIC output stage
  localparam int E1   = 3 + QW;              // energy saturate, eV series start
  localparam int L    = E1 + 6;              // total stages
  localparam int LAST = L - 1;
  localparam int NM   = LAST - C0;
  localparam int NA   = LAST - 1 - CEND;

  // ---------------- stage control ----------------
  logic [L-1:0] v;
  logic [L-1:0] load;

  for (genvar i = 0; i < L; i++) begin : g_load
    if (i == L - 1) begin : g_end
      assign load[i] = !v[i] || out_ready;
    end else begin : g_mid
      assign load[i] = !v[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < L; i++) begin
        if (load[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_ready  = load[0];
  assign out_valid = v[LAST];

  // ---------------- configuration ----------------
  logic [MASS_W-1:0] particle_mass;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_mass <= MASS_RESET;
    end else if (cfg_we) begin
      particle_mass <= cfg_data;
    end
  end

  // ---------------- stage 0: input register ----------------
  logic signed [MW-1:0] px0, py0, pz0;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      px0 <= in_data.mom_x;
      py0 <= in_data.mom_y;
      pz0 <= in_data.mom_z;
    end
  end

  // ---------------- stage 1: squares ----------------
  logic [MW-1:0]        ax, ay, az;
  logic [2*MW-1:0]      sqx, sqy, sqz;
  logic signed [MW-1:0] px1, py1, pz1;

  // most negative input wraps to its own unsigned magnitude
  assign ax = MW'(px0 < 0 ? -px0 : px0);
  assign ay = MW'(py0 < 0 ? -py0 : py0);
  assign az = MW'(pz0 < 0 ? -pz0 : pz0);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      sqx <= (2*MW)'(ax) * (2*MW)'(ax);
      sqy <= (2*MW)'(ay) * (2*MW)'(ay);
      sqz <= (2*MW)'(az) * (2*MW)'(az);
      px1 <= px0;
      py1 <= py0;
      pz1 <= pz0;
    end
  end

  // ---------------- stage 2: sums ----------------
  logic [2*MW:0]        sxy;
  logic [SW-1:0]        ssum;
  logic signed [MW-1:0] px2, py2, pz2;
  logic [2*MW:0]        sxy_next;

  assign sxy_next = (2*MW+1)'(sqx) + (2*MW+1)'(sqy);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      sxy  <= sxy_next;
      ssum <= SW'(sxy_next) + SW'(sqz);
      px2  <= px1;
      py2  <= py1;
      pz2  <= pz1;
    end
  end

  // ---------------- square roots ----------------
  logic [SQ-1:0] mag_root, rxy_root;

  mts_sqrt #(.NW(SW)) u_sqrt_mag (
    .clk      (clk),
    .load     (load[3 +: SQ]),
    .num      (ssum),
    .root_out (mag_root)
  );

  mts_sqrt #(.NW(SW)) u_sqrt_xy (
    .clk      (clk),
    .load     (load[3 +: SQ]),
    .num      (SW'(sxy)),
    .root_out (rxy_root)
  );

  logic [3*MW-1:0] xyz_d;

  mts_delay #(.W(3*MW), .N(SQ)) u_dly_xyz (
    .clk  (clk),
    .load (load[3 +: SQ]),
    .din  ({px2, py2, pz2}),
    .dout (xyz_d)
  );

  // ---------------- angles ----------------
  logic signed [MW-1:0]  pxd, pyd, pzd;
  logic signed [ANG_W-1:0] azim_c, pol_c;

  assign pxd = signed'(xyz_d[3*MW-1:2*MW]);
  assign pyd = signed'(xyz_d[2*MW-1:MW]);
  assign pzd = signed'(xyz_d[MW-1:0]);

  mts_cordic #(.IW(IW), .STEPS(CS)) u_cordic_az (
    .clk   (clk),
    .load  (load[C0 +: CS+2]),
    .x_in  (IW'(pxd)),
    .y_in  (IW'(pyd)),
    .angle (azim_c)
  );

  // polar angle as atan2(rho_xy, z)
  mts_cordic #(.IW(IW), .STEPS(CS)) u_cordic_pol (
    .clk   (clk),
    .load  (load[C0 +: CS+2]),
    .x_in  (IW'(pzd)),
    .y_in  (signed'({1'b0, rxy_root})),
    .angle (pol_c)
  );

  logic [63:0]      mag_ext;
  logic [MAG_W-1:0] mag_sat, mag_d;

  assign mag_ext = 64'(mag_root);
  assign mag_sat = (mag_ext > 64'(MAG_MAX)) ? MAG_MAX : mag_ext[MAG_W-1:0];

  mts_delay #(.W(MAG_W), .N(NM)) u_dly_mag (
    .clk  (clk),
    .load (load[C0 +: NM]),
    .din  (mag_sat),
    .dout (mag_d)
  );

  logic [2*ANG_W-1:0] ang_d;

  mts_delay #(.W(2*ANG_W), .N(NA)) u_dly_ang (
    .clk  (clk),
    .load (load[CEND+1 +: NA]),
    .din  ({azim_c, pol_c}),
    .dout (ang_d)
  );

  // ---------------- energy ----------------
  logic [QW-1:0] e_quo;

  mts_divider #(.NW(QW), .DW(MASS_W+1)) u_div_mass (
    .clk  (clk),
    .load (load[3 +: QW]),
    .num  (ssum),
    .den  ({particle_mass, 1'b0}),
    .quo  (e_quo)
  );

  logic [QEW-1:0]  e_ext;
  logic            e_over;
  logic [EN_W-1:0] e40;

  assign e_ext  = QEW'(e_quo);
  assign e_over = e_ext > QEW'(ENERGY_MAX);
  assign e40    = e_ext[EN_W-1:0];

  // times 27.2 is 27*E + floor(E/5). E/5 comes from the series
  // E*(3/16)*(1+2^-4)(1+2^-8)(1+2^-16)(1+2^-32), which ends at most 6 low;
  // the remainder (under 32) then adds floor(r/5) as (13*r) >> 6.
  // au_* carries {oversize flag, saturated energy_au}.
  logic [EN_W:0]   au_a, au_b, au_c, au_d, au_e;
  logic [EN_W-1:0] e_a, e_b, e_c;
  logic [EV_W-1:0] e27_a, e27_b, e27_c, e27_d;
  logic [EN_W-1:0] qa, qb, qc, qd;
  logic [EN_W-1:0] qa_s, qb_s, qc_x5;
  logic [5:0]      rd;
  logic [9:0]      r13;
  logic [EV_W-1:0] ev_e;

  assign qa_s  = qa + (qa >> 4);
  assign qb_s  = qb + (qb >> 16);
  assign qc_x5 = (qc << 2) + qc;
  assign r13   = (10'(rd) << 3) + (10'(rd) << 2) + 10'(rd);

  always_ff @(posedge clk) begin
    if (load[E1]) begin
      au_a  <= {e_over, e_over ? ENERGY_MAX : e40};
      e_a   <= e40;
      e27_a <= (EV_W'(e40) << 4) + (EV_W'(e40) << 3) + (EV_W'(e40) << 1) + EV_W'(e40);
      qa    <= (e40 >> 3) + (e40 >> 4);
    end
    if (load[E1+1]) begin
      au_b  <= au_a;
      e_b   <= e_a;
      e27_b <= e27_a;
      qb    <= qa_s + (qa_s >> 8);
    end
    if (load[E1+2]) begin
      au_c  <= au_b;
      e_c   <= e_b;
      e27_c <= e27_b;
      qc    <= qb_s + (qb_s >> 32);
    end
    if (load[E1+3]) begin
      au_d  <= au_c;
      e27_d <= e27_c;
      qd    <= qc;
      rd    <= 6'(e_c - qc_x5);
    end
    if (load[E1+4]) begin
      au_e <= au_d;
      ev_e <= e27_d + EV_W'(qd) + EV_W'(r13[9:6]);
    end
  end

  // ---------------- output stage ----------------
  mts_out_t              out_next;
  logic                  e_sat;
  logic signed [ANG_W-1:0] pol_d;

  assign pol_d = signed'(ang_d[ANG_W-1:0]);
  // zero mass or an oversized quotient saturates both energies
  assign e_sat = (particle_mass == '0) || au_e[EN_W];

  always_comb begin
    out_next.magnitude   = mag_d;
    out_next.azimuth     = signed'(ang_d[2*ANG_W-1:ANG_W]);
    out_next.polar_angle = (pol_d < 0) ? '0 : pol_d[POL_W-1:0];
    out_next.energy_au   = e_sat ? ENERGY_MAX : au_e[EN_W-1:0];
    if (e_sat || ev_e > EV_W'(ENERGY_MAX)) begin
      out_next.energy_ev = ENERGY_MAX;
    end else begin
      out_next.energy_ev = ev_e[EN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[LAST]) begin
      out_data <= out_next;
    end
  end

endmodule

FILE: test/momentum_to_spherical_energy_test.sv
// ----------------------------------------------------------------------------
// momentum_to_spherical_energy_test: self-checking bench for the vector block
// Drives momentum words through valid/ready, predicts magnitude, angles and
// energies per word, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected-result store and check; prediction happens when a word is taken.
class spherical_scoreboard;
  mts_pkg::mts_out_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // exact integer square root
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // vectoring CORDIC atan2, 13 fraction bits out
  function automatic longint angle_of(longint x, longint y);
    longint acc, nx, ny, r;
    acc = 0;
    if (y == 0) return (x < 0) ? 25736 : 0;
    if (x < 0) begin
      acc = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    x = x <<< mts_pkg::PRESCALE;
    y = y <<< mts_pkg::PRESCALE;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        acc += mts_pkg::ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        acc -= mts_pkg::ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    r = (acc + 4) >>> 3;
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  function void note_input(mts_pkg::mts_in_t w, logic [31:0] mass);
    mts_pkg::mts_out_t o;
    longint px, py, pz, azim, pol;
    longint unsigned sxy, s, mag, e, ev;
    px = w.mom_x;
    py = w.mom_y;
    pz = w.mom_z;
    sxy = px * px + py * py;
    s = sxy + pz * pz;
    mag = isqrt(s);
    azim = angle_of(px, py);
    pol = angle_of(pz, longint'(isqrt(sxy)));
    if (mag > 64'hFFFFFF) mag = 64'hFFFFFF;
    if (pol < 0) pol = 0;
    o.magnitude = mag[23:0];
    o.azimuth = azim[15:0];
    o.polar_angle = pol[14:0];
    if (mass == 0) begin
      o.energy_au = mts_pkg::ENERGY_MAX;
      o.energy_ev = mts_pkg::ENERGY_MAX;
    end else begin
      e = s / (2 * longint'(mass));
      if (e > 64'hFF_FFFF_FFFF) begin
        o.energy_au = mts_pkg::ENERGY_MAX;
        o.energy_ev = mts_pkg::ENERGY_MAX;
      end else begin
        ev = e * 272 / 10;
        o.energy_au = e[39:0];
        o.energy_ev = (ev > 64'hFF_FFFF_FFFF) ? mts_pkg::ENERGY_MAX : ev[39:0];
      end
    end
    pending = {pending, o};
  endfunction

  function void check_result(mts_pkg::mts_out_t got);
    mts_pkg::mts_out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.magnitude !== want.magnitude) begin
      $display("%0t: magnitude exp %0d got %0d", $time, want.magnitude, got.magnitude);
      errors++;
    end
    if (got.azimuth !== want.azimuth) begin
      $display("%0t: azimuth exp %0d got %0d", $time, want.azimuth, got.azimuth);
      errors++;
    end
    if (got.polar_angle !== want.polar_angle) begin
      $display("%0t: polar exp %0d got %0d", $time, want.polar_angle, got.polar_angle);
      errors++;
    end
    if (got.energy_au !== want.energy_au) begin
      $display("%0t: energy_au exp %0d got %0d", $time, want.energy_au, got.energy_au);
      errors++;
    end
    if (got.energy_ev !== want.energy_ev) begin
      $display("%0t: energy_ev exp %0d got %0d", $time, want.energy_ev, got.energy_ev);
      errors++;
    end
  endfunction
endclass

module momentum_to_spherical_energy_test;
  import mts_pkg::*;

  localparam int LATENCY = 2 * MOM_W + 10;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mts_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mts_out_t out_data;
  logic cfg_we = 1'b0;
  logic [MASS_W-1:0] cfg_data = '0;

  // mass register as the block holds it
  logic [MASS_W-1:0] mass_now = MASS_RESET;

  // idling percentages per phase; hold_off forces a long output stall
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  bit timed_out = 1'b0;
  int quiet_cycles = 0;

  spherical_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  momentum_to_spherical_energy dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // both sides: note accepted words on the same edge the block takes them, check taken results
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_data, mass_now);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: random stalls, or a held-off stretch
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one word: optional idle gap, then hold valid until taken
  task automatic send_word(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mom_x: x, mom_y: y, mom_z: z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // only called while drained
  task automatic write_mass(logic [MASS_W-1:0] m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mass_now = m;
  endtask

  // mostly full range vectors, some small, some zero components
  task automatic send_random();
    logic [23:0] v[3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(5))
        0: v[k] = '0;
        1, 2: v[k] = $urandom_range(4095) - 2048;
        default: v[k] = $urandom;
      endcase
    end
    send_word(v[0], v[1], v[2]);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset mass, extremes, axes, zero vector, sign quadrants
    send_word(24'h0, 24'h0, 24'h0);
    send_word(24'h7FFFFF, 24'h0, 24'h0);
    send_word(24'h800000, 24'h0, 24'h0);
    send_word(24'h0, 24'h7FFFFF, 24'h0);
    send_word(24'h0, 24'h800000, 24'h0);
    send_word(24'h0, 24'h0, 24'h7FFFFF);
    send_word(24'h0, 24'h0, 24'h800000);
    send_word(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_word(24'h800000, 24'h800000, 24'h800000);
    send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(24'h000100, 24'hFFFF00, 24'h000100);
    send_word(24'hFFFF00, 24'h000100, 24'hFFFF00);
    send_word(24'hFFFF00, 24'hFFFF00, 24'h0);
    send_word(24'h000001, 24'h000001, 24'h000001);
    send_word(24'h555555, 24'hAAAAAA, 24'h0F0F0F);
    drain();

    // zero mass saturates; minimum and maximum mass
    write_mass('0);
    send_word(24'h0, 24'h0, 24'h0);
    send_word(24'h001000, 24'h0, 24'h0);
    drain();
    write_mass(32'd1);
    send_word(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_word(24'h000010, 24'h0, 24'h0);
    send_word(24'h000001, 24'h0, 24'h0);
    drain();
    write_mass(32'hFFFFFFFF);
    send_word(24'h800000, 24'h800000, 24'h800000);
    send_word(24'h123456, 24'h0, 24'h0);
    drain();

    // random phases with idling profiles and different masses
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_mass(MASS_RESET); end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  write_mass(32'd1); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; write_mass($urandom); end
        3: begin send_idle_pct = 38; recv_stall_pct = 38; write_mass($urandom_range(255, 1)); end
        default: begin send_idle_pct = 0; recv_stall_pct = 20; write_mass(32'hFFFFFFFF); end
      endcase
      for (int n = 0; n < 70; n++) send_random();
      end_burst();
      // sender pauses until all results are in
      drain();
    end

    // long output hold-off while input keeps coming, so the pipe fills
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 150; n++) send_random();
    join
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
